@@ rtl/bfi_pkg.sv @@
// Shared widths, request codes, status codes and command characters of the interpreter.
package bfi_pkg;

  localparam int unsigned REQ_W    = 2;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned STATUS_W = 3;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_PROG  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_INPUT = 2'd1;
  localparam logic [REQ_W-1:0] REQ_RUN   = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_BYTE      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_HALT      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_STEP_LIM  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_UNMATCHED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_TRUNC     = 3'd4;

  // Command characters
  localparam logic [BYTE_W-1:0] CH_RIGHT = 8'h3E;
  localparam logic [BYTE_W-1:0] CH_LEFT  = 8'h3C;
  localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [BYTE_W-1:0] CH_OPEN  = 8'h5B;
  localparam logic [BYTE_W-1:0] CH_CLOSE = 8'h5D;

endpackage

@@ rtl/bfi_req_if.sv @@
// Request channel: program bytes, input bytes and run commands.
interface bfi_req_if;
  logic                         valid;
  logic                         ready;
  logic [bfi_pkg::REQ_W-1:0]    req_type;
  logic [bfi_pkg::BYTE_W-1:0]   data_byte;

  modport source (output valid, output req_type, output data_byte, input ready);
  modport sink   (input valid, input req_type, input data_byte, output ready);
endinterface

@@ rtl/bfi_rsp_if.sv @@
// Result channel: output bytes and the final status beat of each run.
interface bfi_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [bfi_pkg::BYTE_W-1:0]    out_byte;
  logic [bfi_pkg::STATUS_W-1:0]  status;
  logic                          last;

  modport source (output valid, output out_byte, output status, output last, input ready);
  modport sink   (input valid, input out_byte, input status, input last, output ready);
endinterface

@@ rtl/bf_tape_machine_interpreter.sv @@
// Tape-machine interpreter: program/input loader and run sequencer around three memories.
// Load beats (program or input byte) are accepted one per cycle while the sequencer is idle.
// A run first clears the tape, one cell per cycle, then executes: each program byte visited
// is fetched and decoded, ',' with input left adds a tape write of the input byte, each
// byte passed in a bracket scan is read and checked, and an end check precedes the status
// beat; a stalled result side holds '.' and the status beat. Reset sets max_steps to 1000000.
module bf_tape_machine_interpreter #(
  parameter int unsigned PROG_DEPTH = 1024,
  parameter int unsigned TAPE_DEPTH = 256,
  parameter int unsigned IN_DEPTH   = 64,
  parameter int unsigned MAX_OUT    = 63
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bfi_req_if.sink     req_i,
  bfi_rsp_if.source   rsp_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned PC_W = $clog2(PROG_DEPTH + 1);
  localparam int unsigned PA_W = $clog2(PROG_DEPTH);
  localparam int unsigned IL_W = $clog2(IN_DEPTH + 1);
  localparam int unsigned IA_W = (IN_DEPTH > 1) ? $clog2(IN_DEPTH) : 1;
  localparam int unsigned TP_W = $clog2(TAPE_DEPTH);
  localparam int unsigned OC_W = $clog2(MAX_OUT + 1);

  localparam logic [PC_W-1:0] ProgFull = PC_W'(PROG_DEPTH);
  localparam logic [IL_W-1:0] InFull   = IL_W'(IN_DEPTH);
  localparam logic [TP_W-1:0] TapeLast = TP_W'(TAPE_DEPTH - 1);
  localparam logic [OC_W-1:0] OutMax   = OC_W'(MAX_OUT);

  localparam logic [31:0] MaxStepsRst = 32'd1000000;

  // Sequencer states
  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_CLEAR   = 3'd1;
  localparam logic [2:0] S_FETCH   = 3'd2;
  localparam logic [2:0] S_DECODE  = 3'd3;
  localparam logic [2:0] S_INWR    = 3'd4;
  localparam logic [2:0] S_SCAN_RD = 3'd5;
  localparam logic [2:0] S_SCAN_CK = 3'd6;
  localparam logic [2:0] S_DONE    = 3'd7;

  logic [2:0]          state_q, state_d;
  logic [PC_W-1:0]     pc_q, pc_d;
  logic [PC_W-1:0]     plen_q, plen_d;
  logic [PC_W-1:0]     depth_q, depth_d;
  logic [IL_W-1:0]     ilen_q, ilen_d;
  logic [IL_W-1:0]     ridx_q, ridx_d;
  logic [TP_W-1:0]     ptr_q, ptr_d;
  logic [31:0]         steps_q, steps_d;
  logic [OC_W-1:0]     ocnt_q, ocnt_d;
  logic                trunc_q, trunc_d;
  logic                fwd_q, fwd_d;
  logic [2:0]          stat_q, stat_d;
  logic [31:0]         max_steps_q;

  logic                rsp_valid_q;
  logic [7:0]          rsp_byte_q;
  logic [2:0]          rsp_status_q;
  logic                rsp_last_q;

  // Memories and their read data registers
  logic [7:0]          prog_mem [PROG_DEPTH];
  logic [7:0]          in_mem   [IN_DEPTH];
  logic [7:0]          tape_mem [TAPE_DEPTH];
  logic [7:0]          prog_rd_q;
  logic [7:0]          in_rd_q;
  logic [7:0]          tape_rd_q;

  logic                prog_we, prog_re, in_we, in_re, tape_we, tape_re;
  logic [PA_W-1:0]     prog_raddr;
  logic [7:0]          tape_wdata;
  logic [PC_W-1:0]     pc_m1;

  logic                out_free;
  logic                rsp_set;
  logic [7:0]          set_byte;
  logic [2:0]          set_status;
  logic                set_last;
  logic                is_cmd;
  logic                dot_emit;
  logic [7:0]          open_ch, close_ch;

  assign pc_m1    = pc_q - 1'b1;
  assign out_free = !rsp_valid_q || rsp_o.ready;
  assign is_cmd   = (prog_rd_q == bfi_pkg::CH_RIGHT) || (prog_rd_q == bfi_pkg::CH_LEFT) ||
                    (prog_rd_q == bfi_pkg::CH_PLUS)  || (prog_rd_q == bfi_pkg::CH_MINUS) ||
                    (prog_rd_q == bfi_pkg::CH_DOT)   || (prog_rd_q == bfi_pkg::CH_COMMA) ||
                    (prog_rd_q == bfi_pkg::CH_OPEN)  || (prog_rd_q == bfi_pkg::CH_CLOSE);
  assign dot_emit = (prog_rd_q == bfi_pkg::CH_DOT) && (ocnt_q < OutMax);
  assign open_ch  = fwd_q ? bfi_pkg::CH_OPEN : bfi_pkg::CH_CLOSE;
  assign close_ch = fwd_q ? bfi_pkg::CH_CLOSE : bfi_pkg::CH_OPEN;

  // Sequencer next state
  always_comb begin
    state_d    = state_q;
    pc_d       = pc_q;
    plen_d     = plen_q;
    depth_d    = depth_q;
    ilen_d     = ilen_q;
    ridx_d     = ridx_q;
    ptr_d      = ptr_q;
    steps_d    = steps_q;
    ocnt_d     = ocnt_q;
    trunc_d    = trunc_q;
    fwd_d      = fwd_q;
    stat_d     = stat_q;
    prog_we    = 1'b0;
    prog_re    = 1'b0;
    prog_raddr = pc_q[PA_W-1:0];
    in_we      = 1'b0;
    in_re      = 1'b0;
    tape_we    = 1'b0;
    tape_re    = 1'b0;
    tape_wdata = 8'd0;
    rsp_set    = 1'b0;
    set_byte   = 8'd0;
    set_status = bfi_pkg::ST_BYTE;
    set_last   = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          case (req_i.req_type)
            bfi_pkg::REQ_PROG: begin
              if (plen_q < ProgFull) begin
                prog_we = 1'b1;
                plen_d  = plen_q + 1'b1;
              end
            end
            bfi_pkg::REQ_INPUT: begin
              if (ilen_q < InFull) begin
                in_we  = 1'b1;
                ilen_d = ilen_q + 1'b1;
              end
            end
            bfi_pkg::REQ_RUN: begin
              ptr_d   = '0;
              state_d = S_CLEAR;
            end
            default: ;
          endcase
        end
      end

      // Sweep the tape to zero, then reset the run registers
      S_CLEAR: begin
        tape_we = 1'b1;
        if (ptr_q == TapeLast) begin
          ptr_d   = '0;
          pc_d    = '0;
          steps_d = '0;
          ocnt_d  = '0;
          ridx_d  = '0;
          trunc_d = 1'b0;
          state_d = S_FETCH;
        end else begin
          ptr_d = ptr_q + 1'b1;
        end
      end

      S_FETCH: begin
        if (pc_q >= plen_q) begin
          stat_d  = trunc_q ? bfi_pkg::ST_TRUNC : bfi_pkg::ST_HALT;
          state_d = S_DONE;
        end else begin
          prog_re = 1'b1;
          tape_re = 1'b1;
          state_d = S_DECODE;
        end
      end

      S_DECODE: begin
        if (!is_cmd) begin
          pc_d    = pc_q + 1'b1;
          state_d = S_FETCH;
        end else if (steps_q == max_steps_q) begin
          stat_d  = bfi_pkg::ST_STEP_LIM;
          state_d = S_DONE;
        end else if (dot_emit && !out_free) begin
          // hold until the output register drains
          state_d = S_DECODE;
        end else begin
          steps_d = steps_q + 32'd1;
          pc_d    = pc_q + 1'b1;
          state_d = S_FETCH;
          case (prog_rd_q)
            bfi_pkg::CH_RIGHT: ptr_d = (ptr_q == TapeLast) ? '0 : ptr_q + 1'b1;
            bfi_pkg::CH_LEFT:  ptr_d = (ptr_q == '0) ? TapeLast : ptr_q - 1'b1;
            bfi_pkg::CH_PLUS: begin
              tape_we    = 1'b1;
              tape_wdata = tape_rd_q + 8'd1;
            end
            bfi_pkg::CH_MINUS: begin
              tape_we    = 1'b1;
              tape_wdata = tape_rd_q - 8'd1;
            end
            bfi_pkg::CH_DOT: begin
              if (dot_emit) begin
                rsp_set  = 1'b1;
                set_byte = tape_rd_q;
                ocnt_d   = ocnt_q + 1'b1;
              end else begin
                trunc_d = 1'b1;
              end
            end
            bfi_pkg::CH_COMMA: begin
              if (ridx_q < ilen_q) begin
                in_re   = 1'b1;
                state_d = S_INWR;
              end else begin
                tape_we = 1'b1;
              end
            end
            bfi_pkg::CH_OPEN: begin
              if (tape_rd_q == 8'd0) begin
                depth_d = PC_W'(1);
                fwd_d   = 1'b1;
                state_d = S_SCAN_RD;
              end
            end
            bfi_pkg::CH_CLOSE: begin
              if (tape_rd_q != 8'd0) begin
                depth_d = PC_W'(1);
                fwd_d   = 1'b0;
                pc_d    = pc_q;
                state_d = S_SCAN_RD;
              end
            end
            default: ;
          endcase
        end
      end

      // Store the input byte read in the decode cycle
      S_INWR: begin
        tape_we    = 1'b1;
        tape_wdata = in_rd_q;
        ridx_d     = ridx_q + 1'b1;
        state_d    = S_FETCH;
      end

      // Bracket scan: bound check and read of the next byte
      S_SCAN_RD: begin
        if (fwd_q) begin
          if (pc_q >= plen_q) begin
            stat_d  = bfi_pkg::ST_UNMATCHED;
            state_d = S_DONE;
          end else begin
            prog_re = 1'b1;
            state_d = S_SCAN_CK;
          end
        end else begin
          if (pc_q == '0) begin
            stat_d  = bfi_pkg::ST_UNMATCHED;
            state_d = S_DONE;
          end else begin
            pc_d       = pc_m1;
            prog_re    = 1'b1;
            prog_raddr = pc_m1[PA_W-1:0];
            state_d    = S_SCAN_CK;
          end
        end
      end

      // Bracket scan: track nesting depth, resume after the match
      S_SCAN_CK: begin
        state_d = S_SCAN_RD;
        if (fwd_q) pc_d = pc_q + 1'b1;
        if (prog_rd_q == close_ch) begin
          if (depth_q == PC_W'(1)) begin
            pc_d    = pc_q + 1'b1;
            state_d = S_FETCH;
          end else begin
            depth_d = depth_q - 1'b1;
          end
        end else if (prog_rd_q == open_ch) begin
          depth_d = depth_q + 1'b1;
        end
      end

      // Send the status beat and drop the loaded program and input
      S_DONE: begin
        if (out_free) begin
          rsp_set    = 1'b1;
          set_status = stat_q;
          set_last   = 1'b1;
          plen_d     = '0;
          ilen_d     = '0;
          state_d    = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pc_q        <= '0;
      plen_q      <= '0;
      depth_q     <= '0;
      ilen_q      <= '0;
      ridx_q      <= '0;
      ptr_q       <= '0;
      steps_q     <= '0;
      ocnt_q      <= '0;
      trunc_q     <= 1'b0;
      fwd_q       <= 1'b0;
      stat_q      <= bfi_pkg::ST_HALT;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      plen_q  <= plen_d;
      depth_q <= depth_d;
      ilen_q  <= ilen_d;
      ridx_q  <= ridx_d;
      ptr_q   <= ptr_d;
      steps_q <= steps_d;
      ocnt_q  <= ocnt_d;
      trunc_q <= trunc_d;
      fwd_q   <= fwd_d;
      stat_q  <= stat_d;
      if (rsp_set) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (rsp_set) begin
      rsp_byte_q   <= set_byte;
      rsp_status_q <= set_status;
      rsp_last_q   <= set_last;
    end
  end

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_steps_q <= MaxStepsRst;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      max_steps_q <= pwdata;
    end
  end

  // Program memory
  always_ff @(posedge clk_i) begin
    if (prog_we) prog_mem[plen_q[PA_W-1:0]] <= req_i.data_byte;
    if (prog_re) prog_rd_q <= prog_mem[prog_raddr];
  end

  // Input memory
  always_ff @(posedge clk_i) begin
    if (in_we) in_mem[ilen_q[IA_W-1:0]] <= req_i.data_byte;
    if (in_re) in_rd_q <= in_mem[ridx_q[IA_W-1:0]];
  end

  // Tape memory
  always_ff @(posedge clk_i) begin
    if (tape_we) tape_mem[ptr_q] <= tape_wdata;
    if (tape_re) tape_rd_q <= tape_mem[ptr_q];
  end

  assign req_i.ready    = (state_q == S_IDLE);
  assign rsp_o.valid    = rsp_valid_q;
  assign rsp_o.out_byte = rsp_byte_q;
  assign rsp_o.status   = rsp_status_q;
  assign rsp_o.last     = rsp_last_q;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : max_steps_q;

endmodule

@@ rtl/bfi_checker.sv @@
// Port-level checker for the tape-machine interpreter, with its bind.
module bfi_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           req_valid_i,
  input logic                           req_ready_i,
  input logic [bfi_pkg::REQ_W-1:0]      req_type_i,
  input logic                           rsp_valid_i,
  input logic                           rsp_ready_i,
  input logic [bfi_pkg::BYTE_W-1:0]     rsp_out_byte_i,
  input logic [bfi_pkg::STATUS_W-1:0]   rsp_status_i,
  input logic                           rsp_last_i
);

  // Hold a stalled result beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_out_byte_i) &&
      $stable(rsp_status_i) && $stable(rsp_last_i))
    else $error("result beat changed while stalled");

  // A run holds off further requests
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i && (req_type_i == bfi_pkg::REQ_RUN) |=> !req_ready_i)
    else $error("request accepted right after a run");

  // Final beat carries a status and a zero byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_last_i |-> (rsp_out_byte_i == 8'd0) &&
      (rsp_status_i != bfi_pkg::ST_BYTE))
    else $error("malformed status beat");

  // Non-final beats are output bytes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_last_i |-> rsp_status_i == bfi_pkg::ST_BYTE)
    else $error("output beat with status code");

endmodule

bind bf_tape_machine_interpreter bfi_checker u_bfi_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .req_valid_i    (req_i.valid),
  .req_ready_i    (req_i.ready),
  .req_type_i     (req_i.req_type),
  .rsp_valid_i    (rsp_o.valid),
  .rsp_ready_i    (rsp_o.ready),
  .rsp_out_byte_i (rsp_o.out_byte),
  .rsp_status_i   (rsp_o.status),
  .rsp_last_i     (rsp_o.last)
);

@@ tb/sv/tb_bf_tape_machine_interpreter.sv @@
// Self-checking regression bench for the tape-machine interpreter: stimulus, scoreboard, watchdog.
module tb_bf_tape_machine_interpreter;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PROG_DEPTH = 1024;
  localparam int unsigned TAPE_DEPTH = 256;
  localparam int unsigned IN_DEPTH   = 64;
  localparam int unsigned MAX_OUT    = 63;

  localparam logic [bfi_pkg::REQ_W-1:0] REQ_NOP = 2'd3;  // undefined request code
  localparam logic [2:0]       ADDR_MAX_STEPS = 3'd0;
  localparam logic [31:0]      STEPS_AT_RESET = 32'd1000000;

  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned END_CYCLES    = 64;
  localparam int unsigned LONG_HOLD     = 600;
  localparam int unsigned CYCLE_LIMIT   = 4000000;
  localparam int unsigned SHOWN_FAULTS  = 10;

  typedef struct packed {
    logic [bfi_pkg::BYTE_W-1:0]   out_byte;
    logic [bfi_pkg::STATUS_W-1:0] status;
    logic                         last;
  } rsp_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = ADDR_MAX_STEPS;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  bfi_req_if req_if ();
  bfi_rsp_if rsp_if ();

  bf_tape_machine_interpreter #(
    .PROG_DEPTH (PROG_DEPTH),
    .TAPE_DEPTH (TAPE_DEPTH),
    .IN_DEPTH   (IN_DEPTH),
    .MAX_OUT    (MAX_OUT)
  ) i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .rsp_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predictor state: loaded program and input, step budget
  logic [bfi_pkg::BYTE_W-1:0] prog_mem [PROG_DEPTH];
  logic [bfi_pkg::BYTE_W-1:0] input_mem [IN_DEPTH];
  logic [bfi_pkg::BYTE_W-1:0] tape_model [TAPE_DEPTH];
  int unsigned       prog_len = 0;
  int unsigned       input_len = 0;
  logic [31:0]       step_budget = STEPS_AT_RESET;

  rsp_beat_t                  expected_results [$];
  logic [bfi_pkg::BYTE_W-1:0] prog_q [$];
  logic [bfi_pkg::BYTE_W-1:0] data_q [$];

  int unsigned src_idle_pct = 0;
  int unsigned snk_stall_pct = 0;
  int unsigned hold_left = 0;
  int unsigned fault_count = 0;
  int unsigned beats_sent = 0;
  int unsigned runs_sent = 0;
  int unsigned results_seen = 0;
  int unsigned status_tally [8];
  int unsigned cycle_count = 0;

  always #1 clk_i = ~clk_i;

  function automatic void flag_fault(input string msg);
    fault_count++;
    if (fault_count <= SHOWN_FAULTS) $display("MISMATCH: %s", msg);
  endfunction

  function automatic bit is_command(input logic [bfi_pkg::BYTE_W-1:0] c);
    return c == bfi_pkg::CH_RIGHT || c == bfi_pkg::CH_LEFT || c == bfi_pkg::CH_PLUS ||
           c == bfi_pkg::CH_MINUS || c == bfi_pkg::CH_DOT || c == bfi_pkg::CH_COMMA ||
           c == bfi_pkg::CH_OPEN || c == bfi_pkg::CH_CLOSE;
  endfunction

  function automatic void expect_beat(input logic [bfi_pkg::BYTE_W-1:0] b,
                                      input logic [bfi_pkg::STATUS_W-1:0] s,
                                      input logic l);
    rsp_beat_t r;
    r.out_byte = b;
    r.status   = s;
    r.last     = l;
    expected_results.push_back(r);
  endfunction

  // Execute the loaded program and queue the beats it should produce
  task automatic interpret_program();
    int unsigned                  ptr, pc, outs, rd, depth, j;
    logic [31:0]                  steps;
    logic [bfi_pkg::BYTE_W-1:0]   c;
    logic [bfi_pkg::STATUS_W-1:0] ending;
    bit                           truncated, done;
    foreach (tape_model[k]) tape_model[k] = '0;
    ptr = 0;
    pc = 0;
    outs = 0;
    rd = 0;
    steps = '0;
    truncated = 1'b0;
    done = 1'b0;
    ending = bfi_pkg::ST_HALT;
    while (!done && pc < prog_len) begin
      c = prog_mem[pc];
      if (!is_command(c)) begin
        pc++;
      end else if (steps == step_budget) begin
        ending = bfi_pkg::ST_STEP_LIM;
        done = 1'b1;
      end else begin
        steps++;
        case (c)
          bfi_pkg::CH_RIGHT: ptr = (ptr + 1) % TAPE_DEPTH;
          bfi_pkg::CH_LEFT:  ptr = (ptr == 0) ? TAPE_DEPTH - 1 : ptr - 1;
          bfi_pkg::CH_PLUS:  tape_model[ptr] = tape_model[ptr] + 8'd1;
          bfi_pkg::CH_MINUS: tape_model[ptr] = tape_model[ptr] - 8'd1;
          bfi_pkg::CH_DOT: begin
            if (outs < MAX_OUT) begin
              expect_beat(tape_model[ptr], bfi_pkg::ST_BYTE, 1'b0);
              outs++;
            end else begin
              truncated = 1'b1;
            end
          end
          bfi_pkg::CH_COMMA: begin
            if (rd < input_len) begin
              tape_model[ptr] = input_mem[rd];
              rd++;
            end else begin
              tape_model[ptr] = '0;
            end
          end
          bfi_pkg::CH_OPEN: begin
            if (tape_model[ptr] == 0) begin
              depth = 1;
              j = pc;
              while (depth != 0 && j + 1 < prog_len) begin
                j++;
                if (prog_mem[j] == bfi_pkg::CH_OPEN) depth++;
                else if (prog_mem[j] == bfi_pkg::CH_CLOSE) depth--;
              end
              if (depth != 0) begin
                ending = bfi_pkg::ST_UNMATCHED;
                done = 1'b1;
              end else begin
                pc = j;
              end
            end
          end
          default: begin
            if (tape_model[ptr] != 0) begin
              depth = 1;
              j = pc;
              while (depth != 0 && j > 0) begin
                j--;
                if (prog_mem[j] == bfi_pkg::CH_CLOSE) depth++;
                else if (prog_mem[j] == bfi_pkg::CH_OPEN) depth--;
              end
              if (depth != 0) begin
                ending = bfi_pkg::ST_UNMATCHED;
                done = 1'b1;
              end else begin
                pc = j;
              end
            end
          end
        endcase
        if (!done) pc++;
      end
    end
    if (!done && truncated) ending = bfi_pkg::ST_TRUNC;
    expect_beat('0, ending, 1'b1);
    prog_len = 0;
    input_len = 0;
  endtask

  // Update the predictor with one accepted request beat
  task automatic apply_beat(input logic [bfi_pkg::REQ_W-1:0] kind,
                            input logic [bfi_pkg::BYTE_W-1:0] val);
    case (kind)
      bfi_pkg::REQ_PROG: begin
        if (prog_len < PROG_DEPTH) begin
          prog_mem[prog_len] = val;
          prog_len++;
        end
      end
      bfi_pkg::REQ_INPUT: begin
        if (input_len < IN_DEPTH) begin
          input_mem[input_len] = val;
          input_len++;
        end
      end
      bfi_pkg::REQ_RUN: begin
        runs_sent++;
        interpret_program();
      end
      default: ;
    endcase
  endtask

  // Offer one request beat, with random idle gaps ahead of it
  task automatic send_beat(input logic [bfi_pkg::REQ_W-1:0] kind,
                           input logic [bfi_pkg::BYTE_W-1:0] val);
    @(negedge clk_i);
    if ($urandom_range(0, 99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(0, 99) < src_idle_pct);
    end
    req_if.valid     <= 1'b1;
    req_if.req_type  <= kind;
    req_if.data_byte <= val;
    do @(posedge clk_i); while (!req_if.ready);
    if (kind != REQ_NOP) beats_sent++;
    apply_beat(kind, val);
  endtask

  // Drop valid and hold until every expected beat has come back
  task automatic wait_drained();
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write max_steps on the register port, then read it back
  task automatic program_step_budget(input logic [31:0] value);
    wait_drained();
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_MAX_STEPS;
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    step_budget = value;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== value)
      flag_fault($sformatf("max_steps readback: expected %0d, got %0d", value, prdata));
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Send the queued program and input bytes, interleaved, then the run beat
  task automatic load_and_run(input bit with_strays);
    int unsigned pi, di;
    pi = 0;
    di = 0;
    while (pi < prog_q.size() || di < data_q.size()) begin
      if (di < data_q.size() && (pi >= prog_q.size() || $urandom_range(0, 3) == 0)) begin
        send_beat(bfi_pkg::REQ_INPUT, data_q[di]);
        di++;
      end else begin
        send_beat(bfi_pkg::REQ_PROG, prog_q[pi]);
        pi++;
      end
      if (with_strays && $urandom_range(0, 99) < 4)
        send_beat(REQ_NOP, 8'($urandom_range(0, 255)));
    end
    send_beat(bfi_pkg::REQ_RUN, 8'($urandom_range(0, 255)));
  endtask

  task automatic queue_text(input string s);
    prog_q.delete();
    data_q.delete();
    foreach (s[k]) prog_q.push_back(s[k]);
  endtask

  function automatic logic [bfi_pkg::BYTE_W-1:0] filler_byte();
    logic [bfi_pkg::BYTE_W-1:0] b;
    do b = 8'($urandom_range(0, 255)); while (is_command(b));
    return b;
  endfunction

  function automatic logic [bfi_pkg::BYTE_W-1:0] pick_command(input int unsigned sel);
    case (sel)
      0: return bfi_pkg::CH_RIGHT;
      1: return bfi_pkg::CH_LEFT;
      2: return bfi_pkg::CH_PLUS;
      3: return bfi_pkg::CH_MINUS;
      4: return bfi_pkg::CH_DOT;
      default: return bfi_pkg::CH_COMMA;
    endcase
  endfunction

  // Build a random program with balanced brackets, at most three deep
  task automatic compose_wellformed();
    int unsigned len, depth, k, r;
    prog_q.delete();
    len = $urandom_range(3, 20);
    depth = 0;
    if ($urandom_range(0, 1))
      prog_q.push_back($urandom_range(0, 1) ? bfi_pkg::CH_COMMA : bfi_pkg::CH_PLUS);
    for (k = 0; k < len; k++) begin
      r = $urandom_range(0, 99);
      if (r < 10 && depth < 3 && k + 4 < len) begin
        prog_q.push_back(bfi_pkg::CH_OPEN);
        depth++;
      end else if (r < 20 && depth > 0) begin
        prog_q.push_back(bfi_pkg::CH_CLOSE);
        depth--;
      end else if (r < 26) begin
        prog_q.push_back(filler_byte());
      end else begin
        prog_q.push_back(pick_command($urandom_range(0, 5)));
      end
    end
    while (depth > 0) begin
      prog_q.push_back(bfi_pkg::CH_CLOSE);
      depth--;
    end
  endtask

  // Ready driver: random stalls, plus long hold-offs counted here
  initial begin : result_ready_driver
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left != 0) begin
        rsp_if.ready <= 1'b0;
        hold_left--;
      end else begin
        rsp_if.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
      end
    end
  end

  // Compare each accepted result beat with the oldest expectation
  always @(posedge clk_i) begin : result_check
    rsp_beat_t got, want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      got.out_byte = rsp_if.out_byte;
      got.status   = rsp_if.status;
      got.last     = rsp_if.last;
      results_seen++;
      if (got.last) status_tally[got.status]++;
      if (expected_results.size() == 0) begin
        flag_fault($sformatf("unexpected beat: byte %0d status %0d last %0d",
                             got.out_byte, got.status, got.last));
      end else begin
        want = expected_results.pop_front();
        if (got !== want)
          flag_fault($sformatf("beat %0d: expected byte %0d status %0d last %0d, got %0d %0d %0d",
                               results_seen, want.out_byte, want.status, want.last,
                               got.out_byte, got.status, got.last));
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("bf_tape_machine_interpreter regression: fail");
    $finish;
  end

  // All commands but the brackets, pointer wrap both ways, 8-bit wrap, input exhausted; reset step budget
  task automatic test_commands_and_wrap();
    queue_text(",+.<-.>,+,.");
    data_q.push_back(8'hFF);
    data_q.push_back(8'h00);
    load_and_run(1'b0);
  endtask

  // Counting loop emits far more than the output limit, with the widest step budget
  task automatic test_output_truncation();
    program_step_budget(32'hFFFF_FFFF);
    queue_text("+[.+]");
    load_and_run(1'b0);
  endtask

  // Forward scan off the end and backward scan off the start
  task automatic test_unmatched_brackets();
    queue_text("[");
    load_and_run(1'b0);
    queue_text("+]");
    load_and_run(1'b0);
  endtask

  // A step budget of one stops at the second command
  task automatic test_step_limit_floor();
    program_step_budget(32'd1);
    queue_text("+.");
    load_and_run(1'b0);
  endtask

  // Appends beyond a full input store are dropped
  task automatic test_store_overflow();
    int unsigned k;
    program_step_budget(32'd5000);
    queue_text(",[.,]");
    for (k = 0; k < IN_DEPTH + 2; k++) data_q.push_back(8'($urandom_range(1, 255)));
    load_and_run(1'b0);
  endtask

  // Hold results off for a long stretch while requests keep coming
  task automatic test_output_backpressure();
    wait_drained();
    src_idle_pct = 0;
    snk_stall_pct = 0;
    hold_left = LONG_HOLD;
    queue_text("+[.+]");
    load_and_run(1'b0);
    queue_text("+++.>,.");
    data_q.push_back(8'h5A);
    load_and_run(1'b0);
    wait_drained();
  endtask

  // Mostly well-formed programs with random content, some noise and broken brackets
  task automatic test_random_programs(input int unsigned beat_goal, input int unsigned src_pct,
                                      input int unsigned snk_pct);
    int unsigned start, pick, n_in, k;
    program_step_budget(32'($urandom_range(20, 400)));
    src_idle_pct = src_pct;
    snk_stall_pct = snk_pct;
    start = beats_sent;
    while (beats_sent - start < beat_goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        prog_q.delete();
        n_in = $urandom_range(1, 12);
        for (k = 0; k < n_in; k++) prog_q.push_back(8'($urandom_range(0, 255)));
      end else begin
        compose_wellformed();
        if (pick < 25)
          prog_q.insert($urandom_range(0, prog_q.size()),
                        $urandom_range(0, 1) ? bfi_pkg::CH_OPEN : bfi_pkg::CH_CLOSE);
      end
      data_q.delete();
      n_in = ($urandom_range(0, 99) < 6) ? $urandom_range(60, 68) : $urandom_range(0, 5);
      for (k = 0; k < n_in; k++) data_q.push_back(8'($urandom_range(0, 255)));
      load_and_run(1'b1);
    end
  endtask

  initial begin : main_sequence
    req_if.valid     = 1'b0;
    req_if.req_type  = bfi_pkg::REQ_PROG;
    req_if.data_byte = '0;
    foreach (status_tally[k]) status_tally[k] = 0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_commands_and_wrap();
    test_output_truncation();
    test_unmatched_brackets();
    test_step_limit_floor();
    test_store_overflow();
    test_output_backpressure();
    test_random_programs(65, 0, 0);
    test_random_programs(65, 56, 0);
    test_random_programs(65, 0, 56);
    test_random_programs(65, 30, 30);

    wait_drained();
    repeat (END_CYCLES) @(posedge clk_i);
    if (expected_results.size() != 0)
      flag_fault($sformatf("%0d expected beats never arrived", expected_results.size()));

    $display("covered %0d request beats in %0d runs, %0d result beats checked",
             beats_sent, runs_sent, results_seen);
    $display("run endings: %0d halt, %0d step limit, %0d unmatched, %0d truncated",
             status_tally[bfi_pkg::ST_HALT], status_tally[bfi_pkg::ST_STEP_LIM],
             status_tally[bfi_pkg::ST_UNMATCHED], status_tally[bfi_pkg::ST_TRUNC]);
    if (fault_count == 0) begin
      $display("bf_tape_machine_interpreter regression: pass");
    end else begin
      $display("%0d mismatches", fault_count);
      $display("bf_tape_machine_interpreter regression: fail");
    end
    $finish;
  end

endmodule
